// File: hdl/fsrc_pkg.sv
// Shared constants, types and register codes for the ramped sine source.
`timescale 1ns / 1ps
`default_nettype none
package fsrc_pkg;

    localparam int TIME_BITS_DEF  = 48;
    localparam int ANGLE_BITS_DEF = 32;

    // Odd polynomial coefficients of the quarter-wave sine, Q30
    localparam logic [31:0] C1 = 32'd1686629713;
    localparam logic [31:0] C3 = 32'd693598668;
    localparam logic [31:0] C5 = 32'd85569306;
    localparam logic [31:0] C7 = 32'd5026996;
    localparam logic [31:0] C9 = 32'd172271;
    localparam logic [31:0] QUARTER = 32'h4000_0000;

    localparam int HORNER_STEPS = 4;
    localparam logic [31:0] HORNER_COEF [HORNER_STEPS] = '{C7, C5, C3, C1};

    typedef enum logic [2:0] {
        REG_VOLTAGE_AMP  = 3'd0,
        REG_PHASE_OFFSET = 3'd1,
        REG_CONDUCTANCE  = 3'd2,
        REG_GRID_FREQ    = 3'd3,
        REG_EXTRA_FREQ   = 3'd4,
        REG_SWITCH_START = 3'd5,
        REG_RAMP_LENGTH  = 3'd6,
        REG_RAMP_RATE    = 3'd7
    } reg_index_t;

    localparam logic [1:0] MODE_BEFORE = 2'd0;
    localparam logic [1:0] MODE_RAMP   = 2'd1;
    localparam logic [1:0] MODE_AFTER  = 2'd2;

    // Data handed from one polynomial cell to the next
    typedef struct packed {
        logic        valid;
        logic        neg;
        logic [30:0] z;
        logic [30:0] z2;
        logic [31:0] p;
    } sin_lane_t;

endpackage
`default_nettype wire

// File: hdl/fsrc_horner_cell.sv
// One Horner step of the sine polynomial: p <= coef - (z2 * p) >> 30.
`timescale 1ns / 1ps
`default_nettype none
module fsrc_horner_cell #(
    parameter logic [31:0] COEF   = fsrc_pkg::C1,
    parameter int          SIDE_W = 1
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  fsrc_pkg::sin_lane_t    lane_in,
    input  wire  [SIDE_W-1:0]      side_in,
    output fsrc_pkg::sin_lane_t    lane_out,
    output logic [SIDE_W-1:0]      side_out
);

    fsrc_pkg::sin_lane_t lane_reg;
    logic [SIDE_W-1:0]   side_reg;
    logic [62:0]         prod;
    logic [31:0]         p_next;

    assign prod   = 63'(lane_in.z2) * 63'(lane_in.p);
    assign p_next = COEF - prod[61:30];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg <= '0;
            side_reg <= '0;
        end
        else
        begin
            lane_reg.valid <= lane_in.valid;
            lane_reg.neg   <= lane_in.neg;
            lane_reg.z     <= lane_in.z;
            lane_reg.z2    <= lane_in.z2;
            lane_reg.p     <= p_next;
            side_reg       <= side_in;
        end
    end

    assign lane_out = lane_reg;
    assign side_out = side_reg;

endmodule
`default_nettype wire

// File: hdl/fsrc_sin_pipe.sv
// Pipelined cosine in Q30 of an angle in turns, built as a chain of Horner cells.
`timescale 1ns / 1ps
`default_nettype none
module fsrc_sin_pipe #(
    parameter int SIDE_W = 1
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    input  wire         [31:0]       angle,
    input  wire         [SIDE_W-1:0] side_in,
    output logic                     out_valid,
    output logic signed [31:0]       value,
    output logic        [SIDE_W-1:0] side_out
);

    localparam int N = fsrc_pkg::HORNER_STEPS;

    // fold stage
    logic [31:0] a_sh;
    logic [31:0] b_fold;
    logic        fold_valid_reg;
    logic        fold_neg_reg;
    logic [30:0] fold_z_reg;
    logic [SIDE_W-1:0] fold_side_reg;

    assign a_sh   = angle + fsrc_pkg::QUARTER;
    assign b_fold = ({1'b0, a_sh[30:0]} > fsrc_pkg::QUARTER) ?
                    (32'h8000_0000 - {1'b0, a_sh[30:0]}) : {1'b0, a_sh[30:0]};

    // square stage
    logic [61:0] zz;
    fsrc_pkg::sin_lane_t lane [N+1];
    logic [SIDE_W-1:0]   side [N+1];
    fsrc_pkg::sin_lane_t sq_reg;
    logic [SIDE_W-1:0]   sq_side_reg;

    assign zz = 62'(fold_z_reg) * 62'(fold_z_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_valid_reg <= 1'b0;
            sq_reg         <= '0;
        end
        else
        begin
            fold_valid_reg <= in_valid;
            sq_reg.valid   <= fold_valid_reg;
            sq_reg.neg     <= fold_neg_reg;
            sq_reg.z       <= fold_z_reg;
            sq_reg.z2      <= zz[60:30];
            sq_reg.p       <= fsrc_pkg::C9;
        end
    end

    always_ff @(posedge clk)
    begin
        fold_neg_reg  <= a_sh[31];
        fold_z_reg    <= b_fold[30:0];
        fold_side_reg <= side_in;
        sq_side_reg   <= fold_side_reg;
    end

    assign lane[0] = sq_reg;
    assign side[0] = sq_side_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        fsrc_horner_cell #(
            .COEF   (fsrc_pkg::HORNER_COEF[i]),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .lane_in  (lane[i]),
            .side_in  (side[i]),
            .lane_out (lane[i+1]),
            .side_out (side[i+1])
        );
    end

    // final product and clamp
    logic [62:0] zp;
    logic        s_valid_reg;
    logic        s_neg_reg;
    logic [32:0] s_reg;
    logic [SIDE_W-1:0] s_side_reg;
    logic [31:0] s_clamp;
    logic        out_valid_reg;
    logic signed [31:0] value_reg;
    logic [SIDE_W-1:0]  out_side_reg;

    assign zp      = 63'(lane[N].z) * 63'(lane[N].p);
    assign s_clamp = (s_reg > 33'(fsrc_pkg::QUARTER)) ? fsrc_pkg::QUARTER : s_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg   <= lane[N].valid;
            out_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s_neg_reg    <= lane[N].neg;
        s_reg        <= zp[62:30];
        s_side_reg   <= side[N];
        value_reg    <= s_neg_reg ? -$signed(s_clamp) : $signed(s_clamp);
        out_side_reg <= s_side_reg;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign side_out  = out_side_reg;

endmodule
`default_nettype wire

// File: hdl/freq_ramped_sine_source_current.sv
// Top level: ramped-frequency sine source voltage and equivalent current.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+-------------------------
//  input    | time_now                                  | start & !busy
//  result   | source_voltage, source_current, ramp_phase| done, one cycle
//  config   | cfg_addr, cfg_wdata                       | cfg_we
//
// One beat per cycle; busy stays low. A beat passes through ramp progress, the
// fade cosine chain, frequency and angle, the main cosine chain, and then
// amplitude, current, rounding and saturation, in that order.
// Reset clears the config registers to their defaults and empties the pipeline.
// Results cannot be held off; each leaves on done for one cycle.
`timescale 1ns / 1ps
`default_nettype none
module freq_ramped_sine_source_current #(
    parameter int TIME_BITS  = fsrc_pkg::TIME_BITS_DEF,
    parameter int ANGLE_BITS = fsrc_pkg::ANGLE_BITS_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire  [TIME_BITS-1:0] time_now,
    output logic                 done,
    output logic signed [31:0]   source_voltage,
    output logic signed [31:0]   source_current,
    output logic [1:0]           ramp_phase,
    input  wire                  cfg_we,
    input  wire  [2:0]           cfg_addr,
    input  wire  [TIME_BITS-1:0] cfg_wdata
);

    localparam logic [31:0] CUT_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
    localparam int SIDE_A = TIME_BITS + 2;

    // configuration
    logic [30:0]          voltage_amp_reg;
    logic [31:0]          phase_offset_reg;
    logic [31:0]          conductance_reg;
    logic [31:0]          grid_freq_reg;
    logic signed [31:0]   extra_freq_reg;
    logic [TIME_BITS-1:0] switch_start_reg;
    logic [TIME_BITS-1:0] ramp_length_reg;
    logic [31:0]          ramp_rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voltage_amp_reg  <= '0;
            phase_offset_reg <= '0;
            conductance_reg  <= 32'd65536;
            grid_freq_reg    <= 32'd3276800;
            extra_freq_reg   <= '0;
            switch_start_reg <= '0;
            ramp_length_reg  <= '0;
            ramp_rate_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (fsrc_pkg::reg_index_t'(cfg_addr))
                fsrc_pkg::REG_VOLTAGE_AMP:  voltage_amp_reg  <= 31'(cfg_wdata);
                fsrc_pkg::REG_PHASE_OFFSET: phase_offset_reg <= 32'(cfg_wdata);
                fsrc_pkg::REG_CONDUCTANCE:  conductance_reg  <= 32'(cfg_wdata);
                fsrc_pkg::REG_GRID_FREQ:    grid_freq_reg    <= 32'(cfg_wdata);
                fsrc_pkg::REG_EXTRA_FREQ:   extra_freq_reg   <= $signed(32'(cfg_wdata));
                fsrc_pkg::REG_SWITCH_START: switch_start_reg <= cfg_wdata;
                fsrc_pkg::REG_RAMP_LENGTH:  ramp_length_reg  <= cfg_wdata;
                fsrc_pkg::REG_RAMP_RATE:    ramp_rate_reg    <= 32'(cfg_wdata);
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic accept;
    assign accept = start & ~busy;

    // stage 1: window classification
    logic [TIME_BITS-1:0] d_comb;
    logic [1:0]           mode_comb;
    assign d_comb = time_now - switch_start_reg;

    always_comb
    begin
        if (time_now < switch_start_reg)
            mode_comb = fsrc_pkg::MODE_BEFORE;
        else if (d_comb < ramp_length_reg)
            mode_comb = fsrc_pkg::MODE_RAMP;
        else
            mode_comb = fsrc_pkg::MODE_AFTER;
    end

    logic                 v1_reg, v2_reg, v3_reg;
    logic [TIME_BITS-1:0] t1_reg, t2_reg, t3_reg;
    logic [TIME_BITS-1:0] d1_reg;
    logic [1:0]           m1_reg, m2_reg, m3_reg;

    // stage 2: progress partial products
    logic [63:0] d64;
    logic [63:0] hi_prod, lo_prod;
    logic [63:0] hi2_reg;
    logic [31:0] lo2_reg;
    assign d64     = 64'(d1_reg);
    assign hi_prod = 64'(d64[63:32]) * 64'(ramp_rate_reg);
    assign lo_prod = 64'(d64[31:0]) * 64'(ramp_rate_reg);

    // stage 3: progress with clamp
    logic [32:0] psum;
    logic [16:0] p_next;
    logic [16:0] p3_reg;
    assign psum = 33'(hi2_reg[23:0]) + 33'(lo2_reg);

    always_comb
    begin
        if (hi2_reg[63:24] != '0 || psum[32:8] > 25'd65536)
            p_next = 17'd65536;
        else
            p_next = psum[24:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg  <= time_now;
        d1_reg  <= d_comb;
        m1_reg  <= mode_comb;
        t2_reg  <= t1_reg;
        m2_reg  <= m1_reg;
        hi2_reg <= hi_prod;
        lo2_reg <= lo_prod[63:32];
        t3_reg  <= t2_reg;
        m3_reg  <= m2_reg;
        p3_reg  <= p_next;
    end

    // fade cosine
    logic               fa_valid;
    logic signed [31:0] fa_cos;
    logic [SIDE_A-1:0]  fa_side;

    fsrc_sin_pipe #(
        .SIDE_W (SIDE_A)
    ) u_fade_cos (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .angle     ({p3_reg[16:0], 15'd0}),
        .side_in   ({m3_reg, t3_reg}),
        .out_valid (fa_valid),
        .value     (fa_cos),
        .side_out  (fa_side)
    );

    // stage 4: fade times extra frequency
    logic signed [32:0] fdiff;
    logic [16:0]        fade;
    logic signed [49:0] fprod;
    assign fdiff = 33'sd1073741824 - 33'(fa_cos);
    assign fade  = fdiff[31:15];
    assign fprod = $signed({1'b0, fade}) * extra_freq_reg;

    logic                 v4_reg, v5_reg, v6_reg, v7_reg;
    logic signed [33:0]   part4_reg;
    logic [TIME_BITS-1:0] t4_reg;
    logic [1:0]           m4_reg, m5_reg, m6_reg, m7_reg;

    // stage 5: instantaneous frequency, low 40 bits
    logic [39:0] f_next;
    logic [39:0] f5_reg, t5_reg;

    always_comb
    begin
        case (m4_reg)
            fsrc_pkg::MODE_RAMP:
                f_next = 40'(grid_freq_reg) + {{6{part4_reg[33]}}, part4_reg};
            fsrc_pkg::MODE_AFTER:
                f_next = 40'(grid_freq_reg) + {{8{extra_freq_reg[31]}}, extra_freq_reg};
            default:
                f_next = 40'(grid_freq_reg);
        endcase
    end

    // stage 6: f * t split in two products
    logic [59:0] ma;
    logic [39:0] mb;
    logic [39:0] ma6_reg;
    logic [19:0] mb6_reg;
    assign ma = 60'(f5_reg) * 60'(t5_reg[19:0]);
    assign mb = 40'(f5_reg[19:0]) * 40'(t5_reg[39:20]);

    // stage 7: angle
    logic [39:0] ft;
    logic [31:0] angle_next;
    logic [31:0] angle7_reg;
    assign ft         = ma6_reg + {mb6_reg, 20'd0};
    assign angle_next = (phase_offset_reg + ft[39:8]) & CUT_MASK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= fa_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        part4_reg  <= fprod[49:16];
        t4_reg     <= fa_side[TIME_BITS-1:0];
        m4_reg     <= fa_side[SIDE_A-1:TIME_BITS];
        f5_reg     <= f_next;
        t5_reg     <= 40'(t4_reg);
        m5_reg     <= m4_reg;
        ma6_reg    <= ma[39:0];
        mb6_reg    <= mb[19:0];
        m6_reg     <= m5_reg;
        angle7_reg <= angle_next;
        m7_reg     <= m6_reg;
    end

    // main cosine
    logic               cb_valid;
    logic signed [31:0] cb_cos;
    logic [1:0]         cb_mode;

    fsrc_sin_pipe #(
        .SIDE_W (2)
    ) u_main_cos (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v7_reg),
        .angle     (angle7_reg),
        .side_in   (m7_reg),
        .out_valid (cb_valid),
        .value     (cb_cos),
        .side_out  (cb_mode)
    );

    // stage 8: amplitude product
    logic [31:0] cmag;
    logic [61:0] vprod;
    assign cmag  = cb_cos[31] ? 32'(-cb_cos) : 32'(cb_cos);
    assign vprod = 62'(voltage_amp_reg) * 62'(cmag[30:0]);

    logic        v8_reg, v9_reg, v10_reg, done_reg;
    logic [61:0] vprod8_reg;
    logic        n8_reg, n9_reg, n10_reg;
    logic [1:0]  m8_reg, m9_reg, m10_reg;

    // stage 9: round and saturate voltage
    logic [62:0] vround;
    logic [31:0] vmag_next;
    assign vround    = 63'(vprod8_reg) + 63'(32'h2000_0000);
    assign vmag_next = (!n8_reg && vround[62:30] > 33'h7FFF_FFFF) ? 32'h7FFF_FFFF :
                       vround[61:30];

    logic [31:0]        vmag9_reg;
    logic signed [31:0] volt9_reg, volt10_reg;

    // stage 10/11: current
    logic [63:0] iprod;
    logic [63:0] iprod10_reg;
    assign iprod = 64'(vmag9_reg) * 64'(conductance_reg);

    logic [64:0] iround;
    logic [31:0] ineg_mag, ipos_mag;
    logic signed [31:0] cur_next;
    assign iround   = 65'(iprod10_reg) + 65'(16'h8000);
    assign ineg_mag = (iround[64:16] > 49'h8000_0000) ? 32'h8000_0000 : iround[47:16];
    assign ipos_mag = (iround[64:16] > 49'h7FFF_FFFF) ? 32'h7FFF_FFFF : iround[47:16];
    assign cur_next = n10_reg ? -$signed(ineg_mag) : $signed(ipos_mag);

    logic signed [31:0] volt_out_reg, cur_out_reg;
    logic [1:0]         mode_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg   <= 1'b0;
            v9_reg   <= 1'b0;
            v10_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v8_reg   <= cb_valid;
            v9_reg   <= v8_reg;
            v10_reg  <= v9_reg;
            done_reg <= v10_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        vprod8_reg   <= vprod;
        n8_reg       <= cb_cos[31];
        m8_reg       <= cb_mode;
        vmag9_reg    <= vmag_next;
        volt9_reg    <= n8_reg ? -$signed(vmag_next) : $signed(vmag_next);
        n9_reg       <= n8_reg;
        m9_reg       <= m8_reg;
        iprod10_reg  <= iprod;
        volt10_reg   <= volt9_reg;
        n10_reg      <= n9_reg;
        m10_reg      <= m9_reg;
        volt_out_reg <= volt10_reg;
        cur_out_reg  <= cur_next;
        mode_out_reg <= m10_reg;
    end

    assign done           = done_reg;
    assign source_voltage = volt_out_reg;
    assign source_current = cur_out_reg;
    assign ramp_phase     = mode_out_reg;

endmodule
`default_nettype wire
